FILE: src/lpfs_pkg.sv
package lpfs_pkg;

	localparam int BYTE_W  = 8;
	localparam int CAP_W   = 17;
	localparam int TOTAL_W = 32;
	localparam int LEN_W   = 32;
	localparam int HOLD_W  = 24;

	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);

	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [CAP_W-1:0]   cap_t;
	typedef logic [TOTAL_W-1:0] total_t;

	localparam cap_t CAP_RESET = cap_t'(1024);

endpackage

FILE: src/lpfs_stream_if.sv
interface lpfs_stream_if;
	import lpfs_pkg::*;

	logic  valid;
	logic  ready;
	byte_t data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

FILE: src/lpfs_frame_if.sv
interface lpfs_frame_if;
	import lpfs_pkg::*;

	logic   valid;
	logic   ready;
	byte_t  out_byte;
	logic   first_of_frame;
	logic   last_of_frame;
	logic   frame_error;
	total_t bytes_delivered;

	modport source (
		output valid, output out_byte, output first_of_frame, output last_of_frame,
		output frame_error, output bytes_delivered, input ready
	);
	modport sink (
		input valid, input out_byte, input first_of_frame, input last_of_frame,
		input frame_error, input bytes_delivered, output ready
	);
endinterface

FILE: src/lpfs_cfg_if.sv
interface lpfs_cfg_if;
	import lpfs_pkg::*;

	logic valid;
	logic ready;
	cap_t buffer_capacity;

	modport source (output valid, output buffer_capacity, input ready);
	modport sink (input valid, input buffer_capacity, output ready);
endinterface

FILE: src/length_prefixed_frame_splitter.sv
// Splits a byte stream into frames, each a 4-byte little-endian signed length header
// followed by that many payload bytes. The block takes one byte per cycle while its
// result queue has room. Header bytes give no output until the fourth arrives; the
// length is then checked against the buffer_capacity register (whole frame, header
// included) and a negative or oversized length gives a single error transaction,
// after which the next header is hunted. A good header is written as one entry into
// an 8-entry result queue and leaves as four transactions, payload bytes following
// one per cycle while the output is ready; the queue absorbs the burst so input runs
// at one byte per cycle unless the output side stalls long enough to fill it.
// bytes_delivered carries the wrapping count of frame bytes sent, this one included.
module length_prefixed_frame_splitter (
	input logic           clk,
	input logic           arst_n,
	lpfs_cfg_if.sink      cfg,
	lpfs_stream_if.sink   stream,
	lpfs_frame_if.source  frames
);
	import lpfs_pkg::*;

	typedef struct packed {
		logic             burst;
		logic             last;
		logic             err;
		logic [LEN_W-1:0] data;
		total_t           total;
	} entry_t;

	localparam logic [PTR_W:0] FULL_COUNT = (PTR_W+1)'(FIFO_DEPTH);

	entry_t              fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [PTR_W:0]      count_q;
	logic [1:0]          sub_q;

	cap_t                cap_q;
	logic [HOLD_W-1:0]   header_hold_q;
	logic [1:0]          header_count_q;
	logic                in_payload_q;
	cap_t                payload_left_q;
	total_t              total_q;

	logic                in_acc;
	logic                out_acc;
	logic                push;
	logic                push_en;
	logic                pop;
	logic                bad_len;
	logic [LEN_W-1:0]    raw;
	logic [LEN_W:0]      whole;
	entry_t              new_entry;
	entry_t              head;

	assign cfg.ready    = 1'b1;
	assign stream.ready = (count_q != FULL_COUNT);
	assign in_acc       = stream.valid && stream.ready;

	assign raw     = {stream.data_byte, header_hold_q};
	assign whole   = {1'b0, raw} + (LEN_W+1)'(4);
	assign bad_len = raw[LEN_W-1] || (whole > (LEN_W+1)'(cap_q));

	always_comb begin
		push           = 1'b0;
		new_entry      = '0;
		new_entry.data = LEN_W'(stream.data_byte);
		if (in_payload_q) begin
			push            = 1'b1;
			new_entry.last  = (payload_left_q == cap_t'(1));
			new_entry.total = total_q + total_t'(1);
		end else if (header_count_q == 2'd3) begin
			push = 1'b1;
			if (bad_len) begin
				new_entry.err   = 1'b1;
				new_entry.data  = '0;
				new_entry.total = total_q;
			end else begin
				new_entry.burst = 1'b1;
				new_entry.data  = raw;
				new_entry.last  = (raw == '0);
				new_entry.total = total_q + total_t'(1);
			end
		end
	end

	assign push_en = in_acc && push;

	// queue head expands a header entry into four transactions
	assign head                   = fifo_q[rd_ptr_q];
	assign frames.valid           = (count_q != '0);
	assign frames.out_byte        = head.data[{sub_q, 3'b000} +: BYTE_W];
	assign frames.first_of_frame  = head.burst && (sub_q == 2'd0);
	assign frames.last_of_frame   = head.last && (!head.burst || (sub_q == 2'd3));
	assign frames.frame_error     = head.err;
	assign frames.bytes_delivered = head.total + total_t'(sub_q);

	assign out_acc = frames.valid && frames.ready;
	assign pop     = out_acc && (!head.burst || (sub_q == 2'd3));

	always_ff @(posedge clk) begin
		if (push_en) begin
			fifo_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			sub_q    <= '0;
		end else begin
			if (push_en) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push_en && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (!push_en && pop) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
			if (out_acc) begin
				sub_q <= pop ? 2'd0 : sub_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q          <= CAP_RESET;
			header_hold_q  <= '0;
			header_count_q <= '0;
			in_payload_q   <= 1'b0;
			payload_left_q <= '0;
			total_q        <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				cap_q <= cfg.buffer_capacity;
			end
			if (in_acc) begin
				if (in_payload_q) begin
					payload_left_q <= payload_left_q - cap_t'(1);
					if (payload_left_q == cap_t'(1)) begin
						in_payload_q <= 1'b0;
					end
					total_q <= total_q + total_t'(1);
				end else if (header_count_q != 2'd3) begin
					header_hold_q[{header_count_q, 3'b000} +: BYTE_W] <= stream.data_byte;
					header_count_q <= header_count_q + 2'd1;
				end else begin
					header_count_q <= '0;
					header_hold_q  <= '0;
					if (!bad_len) begin
						total_q        <= total_q + total_t'(4);
						payload_left_q <= raw[CAP_W-1:0];
						in_payload_q   <= (raw != '0);
					end
				end
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("result queue count beyond depth");

	a_sub_on_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(sub_q != 2'd0) |-> (frames.valid && head.burst))
		else $error("burst index set without a header entry at the head");

	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (payload_left_q != '0))
		else $error("payload phase with nothing left");

	a_header_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(header_count_q != 2'd0) |-> !in_payload_q)
		else $error("header bytes held during payload");

	a_burst_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && head.burst && (sub_q != 2'd3)) |=> (sub_q == $past(sub_q) + 2'd1))
		else $error("header burst did not advance");

endmodule

FILE: test/frame_checker.sv
`timescale 1ns / 100ps

module frame_checker (
	input logic     clk,
	input logic     arst_n,
	lpfs_cfg_if     cfg,
	lpfs_stream_if  stream,
	lpfs_frame_if   frames,
	output int      mismatches,
	output int      outstanding,
	output int      frames_passed,
	output int      headers_rejected
);
	import lpfs_pkg::*;

	typedef struct {
		byte_t  data;
		logic   first;
		logic   last;
		logic   err;
		total_t total;
	} frame_beat_t;

	frame_beat_t expected_beats[$];
	frame_beat_t want;

	cap_t          capacity;
	logic [23:0]   header_hold;
	logic [1:0]    header_count;
	logic          in_payload;
	logic [16:0]   payload_left;
	total_t        total;
	int            errs;
	int            passed;
	int            rejected;

	function automatic void check_field(string field, logic [31:0] exp_val,
		logic [31:0] act_val);
		if (act_val !== exp_val) begin
			errs++;
			$error("%s mismatch: expected %0h, actual %0h", field, exp_val, act_val);
		end
	endfunction

	task automatic split_byte(input byte_t b);
		logic [31:0] len_word;
		logic        last;
		int          k;
		if (in_payload) begin
			payload_left = payload_left - 17'd1;
			last = (payload_left == '0);
			if (last)
				in_payload = 1'b0;
			total = total + total_t'(1);
			expected_beats.push_back('{data: b, first: 1'b0, last: last, err: 1'b0,
				total: total});
		end else if (header_count < 2'd3) begin
			header_hold = header_hold | (24'(b) << (8 * header_count));
			header_count = header_count + 2'd1;
		end else begin
			len_word = {b, header_hold};
			header_count = '0;
			header_hold = '0;
			if (len_word[31] || (33'(len_word) + 33'd4 > 33'(capacity))) begin
				rejected++;
				expected_beats.push_back('{data: 8'h00, first: 1'b0, last: 1'b0,
					err: 1'b1, total: total});
			end else begin
				passed++;
				for (k = 0; k < 4; k++) begin
					total = total + total_t'(1);
					expected_beats.push_back('{data: len_word[8*k +: 8], first: (k == 0),
						last: (k == 3 && len_word == '0), err: 1'b0, total: total});
				end
				payload_left = len_word[16:0];
				in_payload = (len_word != '0);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_beats.delete();
			capacity = CAP_RESET;
			header_hold = '0;
			header_count = '0;
			in_payload = 1'b0;
			payload_left = '0;
			total = '0;
			errs = 0;
			passed = 0;
			rejected = 0;
		end else begin
			// a byte's result is registered in the queue, so outputs are checked before this cycle's byte is split
			if (frames.valid && frames.ready) begin
				if (expected_beats.size() == 0) begin
					errs++;
					$error("unexpected frame transaction: out_byte %0h, frame_error %0b",
						frames.out_byte, frames.frame_error);
				end else begin
					want = expected_beats.pop_front();
					check_field("out_byte", 32'(want.data), 32'(frames.out_byte));
					check_field("first_of_frame", 32'(want.first),
						32'(frames.first_of_frame));
					check_field("last_of_frame", 32'(want.last),
						32'(frames.last_of_frame));
					check_field("frame_error", 32'(want.err), 32'(frames.frame_error));
					check_field("bytes_delivered", want.total, frames.bytes_delivered);
				end
			end
			if (cfg.valid && cfg.ready)
				capacity = cfg.buffer_capacity;
			if (stream.valid && stream.ready)
				split_byte(stream.data_byte);
		end
		mismatches <= errs;
		outstanding <= expected_beats.size();
		frames_passed <= passed;
		headers_rejected <= rejected;
	end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import lpfs_pkg::*;

	localparam int STALL_LIMIT = 1000;

	logic clk;
	logic arst_n;

	lpfs_cfg_if    cfg_bus ();
	lpfs_stream_if byte_bus ();
	lpfs_frame_if  frame_bus ();

	int     mismatches;
	int     outstanding;
	int     frames_passed;
	int     headers_rejected;
	int     stall_cycles;
	int     bytes_sent;
	int     settings_done;
	bit     calm;
	cap_t   cap_now;
	cap_t   phase_caps [7];
	byte_t  byte_plan[$];

	length_prefixed_frame_splitter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.stream (byte_bus),
		.frames (frame_bus)
	);

	frame_checker splitter_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_bus),
		.stream           (byte_bus),
		.frames           (frame_bus),
		.mismatches       (mismatches),
		.outstanding      (outstanding),
		.frames_passed    (frames_passed),
		.headers_rejected (headers_rejected)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int pick_gap();
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic add_header(input logic [31:0] len_word);
		int k;
		for (k = 0; k < 4; k++)
			byte_plan.push_back(len_word[8*k +: 8]);
	endtask

	task automatic add_frame(input int len);
		add_header(32'(len));
		repeat (len)
			byte_plan.push_back(byte_t'($urandom_range(0, 255)));
	endtask

	task automatic plan_random(input int budget);
		int          room;
		int          roll;
		logic [31:0] word;
		room = int'(cap_now) - 4;
		while (byte_plan.size() < budget) begin
			roll = $urandom_range(0, 99);
			if (roll < 60 || (roll < 70 && (room < 0 || room > 12))) begin
				if (room < 0)
					add_header(32'(room + 1));
				else
					add_frame($urandom_range(0, (room < 12) ? room : 12));
			end else if (roll < 70) begin
				add_frame(room);
			end else if (roll < 80) begin
				// one byte past what fits
				add_header(32'(room + 1));
			end else if (roll < 90) begin
				add_header({1'b1, 31'($urandom)});
			end else begin
				word = $urandom;
				if (!word[31])
					word[30] = 1'b1;
				add_header(word);
			end
		end
	endtask

	task automatic send_bytes();
		int gap;
		while (byte_plan.size() > 0) begin
			gap = pick_gap();
			if (gap != 0) begin
				byte_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			byte_bus.valid <= 1'b1;
			byte_bus.data_byte <= byte_plan.pop_front();
			bytes_sent++;
			@(posedge clk);
			while (!byte_bus.ready) @(posedge clk);
		end
		byte_bus.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic set_capacity(input cap_t value);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.buffer_capacity <= value;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		cfg_bus.valid <= 1'b0;
		cap_now = value;
		settings_done++;
	endtask

	initial begin
		int hold;
		frame_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			frame_bus.ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			hold = pick_gap();
			if (hold != 0) begin
				frame_bus.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (byte_bus.valid && byte_bus.ready) ||
			(frame_bus.valid && frame_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n <= 1'b0;
		byte_bus.valid <= 1'b0;
		byte_bus.data_byte <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.buffer_capacity <= '0;
		bytes_sent = 0;
		settings_done = 0;
		calm = 1'b0;
		cap_now = CAP_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// capacity from reset
		add_header(32'd0);
		add_header(32'd2);
		byte_plan.push_back(8'hFF);
		byte_plan.push_back(8'h00);
		add_header(32'hFFFF_FFFF);
		add_header(32'h7FFF_FFFF);
		add_header(32'd1021);
		send_bytes();

		phase_caps[0] = cap_t'(5);
		phase_caps[1] = cap_t'(0);
		phase_caps[2] = cap_t'(65536);
		phase_caps[3] = cap_t'(17'h1FFFF);
		phase_caps[4] = cap_t'($urandom_range(6, 40));
		phase_caps[5] = cap_t'(4);
		phase_caps[6] = CAP_RESET;
		foreach (phase_caps[i]) begin
			set_capacity(phase_caps[i]);
			calm = (i % 3 == 2);
			plan_random(12);
			send_bytes();
		end

		calm = 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);
		$display("%0d stream bytes sent under %0d capacity writes", bytes_sent, settings_done);
		$display("%0d frames passed, %0d headers rejected", frames_passed, headers_rejected);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
